[rtl/wcr_pkg.sv]
// Shared types and constants of the RGB window convolution.
// Used by the controller, the datapath and the top level.
package wcr_pkg;
	localparam int MAX_KERNEL   = 11;
	localparam int MAX_WIDTH    = 1024;
	localparam int COEF_BITS    = 16;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int PIX_MAX      = 255;

	localparam int K_W    = 4;
	localparam int W_W    = 11;
	localparam int H_W    = 13;
	localparam int CFG_W  = 13;
	localparam int ACC_W  = $clog2(MAX_KERNEL * MAX_KERNEL * PIX_MAX + 1);

	// register indexes
	localparam logic [1:0] REG_KERNEL = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// item opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_STREAM = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic produce_now;
		logic last_tap;
		logic busy;
		logic out_free;
	} status_t;
endpackage

[rtl/wcr_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface wcr_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [3:0]  coef_row;
	logic [3:0]  coef_col;
	logic [15:0] coef_value;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	modport source (output valid, op, coef_row, coef_col, coef_value, red_in, green_in,
		blue_in, input ready);
	modport sink (input valid, op, coef_row, coef_col, coef_value, red_in, green_in,
		blue_in, output ready);
endinterface

interface wcr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic        frame_last;
	modport source (output valid, red_out, green_out, blue_out, out_row, out_col,
		frame_last, input ready);
	modport sink (input valid, red_out, green_out, blue_out, out_row, out_col,
		frame_last, output ready);
endinterface

[rtl/wcr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module wcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/wcr_ctrl.sv]
// Controller of the window convolution: sequences accept, tap walk, drain, result.
// Depends on wcr_pkg.
module wcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	input  wcr_pkg::status_t  st,
	output logic              in_ready,
	output wcr_pkg::cmd_t     cmd,
	output wcr_pkg::state_t   state
);
	import wcr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_op == OP_STREAM && st.produce_now) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (st.last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!st.busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.issue    = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_RUN:   cmd.issue = 1'b1;
			ST_DRAIN: ;
			ST_OUT:   cmd.out_load = st.out_free;
			default:  ;
		endcase
	end

	assign state = state_q;
endmodule

[rtl/wcr_dp.sv]
// Datapath of the window convolution: configuration, stream position, stores,
// shared per-channel multiply-accumulate and the result register.
// Depends on wcr_pkg and wcr_ram.
module wcr_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [wcr_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_op,
	input  logic [3:0]                in_coef_row,
	input  logic [3:0]                in_coef_col,
	input  logic [15:0]               in_coef_value,
	input  logic [7:0]                in_red,
	input  logic [7:0]                in_green,
	input  logic [7:0]                in_blue,
	input  wcr_pkg::cmd_t             cmd,
	output wcr_pkg::status_t          st,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [7:0]                red_out,
	output logic [7:0]                green_out,
	output logic [7:0]                blue_out,
	output logic [11:0]               out_row,
	output logic [9:0]                out_col,
	output logic                      frame_last
);
	import wcr_pkg::*;

	localparam int SLOT_W  = $clog2(MAX_KERNEL);
	localparam int XI_W    = $clog2(MAX_WIDTH);
	localparam int LADDR_W = $clog2(MAX_KERNEL * MAX_WIDTH);
	localparam int CADDR_W = $clog2(MAX_KERNEL * MAX_KERNEL);
	localparam int PROD_W  = 8 + COEF_BITS;

	// configuration, stored already clamped
	logic [K_W-1:0] k_q;
	logic [W_W-1:0] w_q;
	logic [H_W-1:0] h_q;
	logic           cfg_hit;

	assign cfg_hit = cfg_we && (cfg_index == REG_KERNEL || cfg_index == REG_WIDTH
		|| cfg_index == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= K_W'(3);
			w_q <= W_W'(640);
			h_q <= H_W'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KERNEL: begin
					if (cfg_data[K_W-1:0] == '0) k_q <= K_W'(1);
					else if (cfg_data[K_W-1:0] > K_W'(MAX_KERNEL)) k_q <= K_W'(MAX_KERNEL);
					else k_q <= cfg_data[K_W-1:0];
				end
				REG_WIDTH: begin
					if (cfg_data[W_W-1:0] == '0) w_q <= W_W'(1);
					else if (cfg_data[W_W-1:0] > W_W'(MAX_WIDTH)) w_q <= W_W'(MAX_WIDTH);
					else w_q <= cfg_data[W_W-1:0];
				end
				REG_HEIGHT: begin
					if (cfg_data[H_W-1:0] == '0) h_q <= H_W'(1);
					else if (cfg_data[H_W-1:0] > H_W'(HEIGHT_LIMIT)) h_q <= H_W'(HEIGHT_LIMIT);
					else h_q <= cfg_data[H_W-1:0];
				end
				default: ;
			endcase
		end
	end

	logic [K_W-1:0] half, ahead;
	assign half  = k_q >> 1;
	assign ahead = k_q - K_W'(1) - half;

	// stream position, with the line slot kept as row modulo the store depth
	logic [H_W-1:0]    r_q, r_e, r_n;
	logic [W_W-1:0]    c_q, c_e, c_n;
	logic [SLOT_W-1:0] s_q, s_e, s_n, s_inc, slot0;
	logic [H_W:0]      r_lim;
	logic [W_W:0]      c_lim;
	logic              wrap, write_px, stream_acc;
	logic [H_W-1:0]    i_e;
	logic [W_W-1:0]    j_e;
	logic [SLOT_W:0]   slot_sum;

	assign r_lim = {1'b0, h_q} + (H_W+1)'(ahead);
	assign c_lim = {1'b0, w_q} + (W_W+1)'(ahead);
	assign wrap  = ({1'b0, r_q} >= r_lim) || ({1'b0, c_q} >= c_lim);
	assign r_e   = wrap ? '0 : r_q;
	assign c_e   = wrap ? '0 : c_q;
	assign s_e   = wrap ? '0 : s_q;
	assign write_px   = (r_e < h_q) && (c_e < w_q);
	assign stream_acc = cmd.accept && in_op == OP_STREAM;
	assign i_e = r_e - H_W'(ahead);
	assign j_e = c_e - W_W'(ahead);
	assign s_inc = (s_e == SLOT_W'(MAX_KERNEL - 1)) ? '0 : s_e + SLOT_W'(1);
	// slot of the first tap row, i - half = r - (k - 1), modulo the store depth
	assign slot_sum = (SLOT_W+1)'(s_e) + (SLOT_W+1)'(MAX_KERNEL) - (SLOT_W+1)'(k_q)
		+ (SLOT_W+1)'(1);
	assign slot0 = (slot_sum >= (SLOT_W+1)'(MAX_KERNEL))
		? SLOT_W'(slot_sum - (SLOT_W+1)'(MAX_KERNEL)) : SLOT_W'(slot_sum);

	// advance the raster position
	always_comb begin
		r_n = r_e;
		s_n = s_e;
		c_n = c_e + W_W'(1);
		if ({1'b0, c_n} >= c_lim) begin
			c_n = '0;
			r_n = r_e + H_W'(1);
			s_n = s_inc;
			if ({1'b0, r_n} >= r_lim) begin
				r_n = '0;
				s_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			s_q <= '0;
		end else if (cfg_hit) begin
			r_q <= '0;
			c_q <= '0;
			s_q <= '0;
		end else if (stream_acc) begin
			r_q <= r_n;
			c_q <= c_n;
			s_q <= s_n;
		end
	end

	assign st.produce_now = (r_e >= H_W'(ahead)) && (c_e >= W_W'(ahead));

	// tap walk over the window
	logic [K_W-1:0]    m_q, n_q;
	logic [SLOT_W-1:0] slot_q;
	logic signed [H_W:0] y_q;
	logic signed [W_W:0] x_q, x0_q;
	logic [11:0]       i_q;
	logic [9:0]        j_q;
	logic              last_q;
	logic              in_range;

	assign st.last_tap = (m_q == k_q - K_W'(1)) && (n_q == k_q - K_W'(1));
	assign in_range = (y_q >= 0) && (y_q < $signed({1'b0, h_q}))
		&& (x_q >= 0) && (x_q < $signed({1'b0, w_q}));

	always_ff @(posedge clk) begin
		if (stream_acc) begin
			m_q    <= '0;
			n_q    <= '0;
			slot_q <= slot0;
			y_q    <= $signed({1'b0, i_e}) - $signed((H_W+1)'(half));
			x0_q   <= $signed({1'b0, j_e}) - $signed((W_W+1)'(half));
			x_q    <= $signed({1'b0, j_e}) - $signed((W_W+1)'(half));
			i_q    <= i_e[11:0];
			j_q    <= j_e[9:0];
			last_q <= (i_e == h_q - H_W'(1)) && (j_e == w_q - W_W'(1));
		end else if (cmd.issue) begin
			if (n_q == k_q - K_W'(1)) begin
				n_q    <= '0;
				m_q    <= m_q + K_W'(1);
				x_q    <= x0_q;
				y_q    <= y_q + 2'sd1;
				slot_q <= (slot_q == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_q + SLOT_W'(1);
			end else begin
				n_q <= n_q + K_W'(1);
				x_q <= x_q + 2'sd1;
			end
		end
	end

	// coefficient and line stores
	logic                 coef_we;
	logic [CADDR_W-1:0]   coef_waddr, coef_raddr;
	logic [COEF_BITS-1:0] coef_rdata;
	logic [LADDR_W-1:0]   line_waddr, line_raddr;
	logic [23:0]          line_rdata;

	assign coef_we = cmd.accept && in_op == OP_LOAD
		&& in_coef_row < 4'(MAX_KERNEL) && in_coef_col < 4'(MAX_KERNEL);
	assign coef_waddr = CADDR_W'(in_coef_row) * CADDR_W'(MAX_KERNEL) + CADDR_W'(in_coef_col);
	assign coef_raddr = CADDR_W'(m_q) * CADDR_W'(MAX_KERNEL) + CADDR_W'(n_q);
	assign line_waddr = LADDR_W'(s_e) * LADDR_W'(MAX_WIDTH) + LADDR_W'(c_e[XI_W-1:0]);
	assign line_raddr = LADDR_W'(slot_q) * LADDR_W'(MAX_WIDTH)
		+ LADDR_W'(x_q[XI_W-1:0]);

	wcr_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_KERNEL * MAX_KERNEL)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (in_coef_value[COEF_BITS-1:0]),
		.re    (cmd.issue),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	wcr_ram #(.WIDTH(24), .DEPTH(MAX_KERNEL * MAX_WIDTH)) u_line_ram (
		.clk   (clk),
		.we    (stream_acc && write_px),
		.waddr (line_waddr),
		.wdata ({in_blue, in_green, in_red}),
		.re    (cmd.issue),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	// multiply, then accumulate
	logic              tap_s1, vld_s1, tap_s2;
	logic [7:0]        prod_r_s2, prod_g_s2, prod_b_s2;
	logic [PROD_W-1:0] pr, pg, pb;
	logic [ACC_W-1:0]  acc_r_q, acc_g_q, acc_b_q;

	assign pr = PROD_W'(line_rdata[7:0])   * PROD_W'(coef_rdata);
	assign pg = PROD_W'(line_rdata[15:8])  * PROD_W'(coef_rdata);
	assign pb = PROD_W'(line_rdata[23:16]) * PROD_W'(coef_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			vld_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			tap_s1 <= cmd.issue;
			vld_s1 <= cmd.issue && in_range;
			tap_s2 <= tap_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_r_s2 <= vld_s1 ? pr[PROD_W-1:COEF_BITS] : '0;
		prod_g_s2 <= vld_s1 ? pg[PROD_W-1:COEF_BITS] : '0;
		prod_b_s2 <= vld_s1 ? pb[PROD_W-1:COEF_BITS] : '0;
		if (stream_acc) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (tap_s2) begin
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s2);
			acc_g_q <= acc_g_q + ACC_W'(prod_g_s2);
			acc_b_q <= acc_b_q + ACC_W'(prod_b_s2);
		end
	end

	assign st.busy = tap_s1 || tap_s2;

	// result register, saturate on load
	logic out_valid_q;
	assign st.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_out    <= (acc_r_q > ACC_W'(PIX_MAX)) ? 8'(PIX_MAX) : acc_r_q[7:0];
			green_out  <= (acc_g_q > ACC_W'(PIX_MAX)) ? 8'(PIX_MAX) : acc_g_q[7:0];
			blue_out   <= (acc_b_q > ACC_W'(PIX_MAX)) ? 8'(PIX_MAX) : acc_b_q[7:0];
			out_row    <= i_q;
			out_col    <= j_q;
			frame_last <= last_q;
		end
	end

	assign out_valid = out_valid_q;
endmodule

[rtl/window_convolution_rgb.sv]
// K by K RGB convolution over a zero-padded raster stream.
// Depends on wcr_pkg, wcr_if, wcr_ctrl and wcr_dp.
//
// Load items (op 0) write one coefficient. When a stream item (op 1) makes a
// pixel due, the block walks the K*K taps through one shared
// multiply-accumulate per channel, one tap a cycle out of the coefficient and
// line RAMs. The result waits in an output register, so the next item is
// taken while it is still pending. Any register write restarts the stream at
// row 0, column 0.
module window_convolution_rgb (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [wcr_pkg::CFG_W-1:0] cfg_data,
	wcr_in_if.sink                    in_ch,
	wcr_out_if.source                 out_ch
);
	import wcr_pkg::*;

	cmd_t    cmd;
	status_t st;
	state_t  state;

	wcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.op),
		.st       (st),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.state    (state)
	);

	wcr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_op         (in_ch.op),
		.in_coef_row   (in_ch.coef_row),
		.in_coef_col   (in_ch.coef_col),
		.in_coef_value (in_ch.coef_value),
		.in_red        (in_ch.red_in),
		.in_green      (in_ch.green_in),
		.in_blue       (in_ch.blue_in),
		.cmd           (cmd),
		.st            (st),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.red_out       (out_ch.red_out),
		.green_out     (out_ch.green_out),
		.blue_out      (out_ch.blue_out),
		.out_row       (out_ch.out_row),
		.out_col       (out_ch.out_col),
		.frame_last    (out_ch.frame_last)
	);

	// no input transfer while the tap walk runs
	a_no_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_RUN) |-> !in_ch.ready)
		else $error("input accepted during tap walk");

	// a result is only loaded once the multiply pipeline has emptied
	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!st.busy && st.out_free))
		else $error("result loaded with taps in flight or slot full");

	// a coefficient load never starts a tap walk
	a_load_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.op == OP_LOAD) |=> (state == ST_IDLE))
		else $error("coefficient load started a tap walk");
endmodule
